/* hdl/dbda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbda_pkg
// shared widths, register indexes, reset values and types for the box decoder
// ----------------------------------------------------------------------------
package dbda_pkg;

   // field widths
   localparam int POS_W   = 15;  // centre and size, q11.4
   localparam int SCALE_W = 16;  // q4.12 scale
   localparam int IMG_W   = 13;  // image size in pixels
   localparam int SCORE_W = 12;  // q0.12 score
   localparam int CNT_W   = 4;   // class count and class index
   localparam int EDGE_W  = 12;  // clamped edge in pixels

   // corner arithmetic
   localparam int MAG_W      = POS_W + 2;          // |2*c +/- s|
   localparam int PROD_W     = MAG_W + SCALE_W;    // product in 2^-17 pixel
   localparam int PROD_SHIFT = 17;

   // score packing
   localparam int SCORES_PER_WORD = 5;
   localparam int SCORE_WORD_W    = SCORES_PER_WORD * SCORE_W;
   localparam int MAX_CLASSES_DEF = 10;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCORE_THRESH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS_COUNT  = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd4096;
   localparam logic [IMG_W-1:0]   IMAGE_RESET  = 13'd640;
   localparam logic [SCORE_W-1:0] THRESH_RESET = 12'd2048;
   localparam logic [CNT_W-1:0]   COUNT_RESET  = 4'd10;

   // per-stage advance strobes shared by all lanes
   typedef struct packed {
      logic s1;
      logic s2;
   } pipe_en_type;

   // one argmax candidate
   typedef struct packed {
      logic               vld;
      logic [SCORE_W-1:0] score;
      logic [CNT_W-1:0]   idx;
   } cand_type;

endpackage

/* hdl/dbda_axis_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbda_axis_lane
// one axis of the box: low and high corner, scaled, truncated and clamped
// ----------------------------------------------------------------------------
module dbda_axis_lane (
   input  logic                        clock,
   input  dbda_pkg::pipe_en_type       en,
   input  logic [dbda_pkg::POS_W-1:0]  centre,
   input  logic [dbda_pkg::POS_W-1:0]  size,
   input  logic [dbda_pkg::SCALE_W-1:0] scale,
   input  logic [dbda_pkg::IMG_W-1:0]  image_size,
   output logic [dbda_pkg::EDGE_W-1:0] lo_edge,
   output logic [dbda_pkg::EDGE_W-1:0] hi_edge
);

   localparam int MAG_W  = dbda_pkg::MAG_W;
   localparam int PROD_W = dbda_pkg::PROD_W;
   localparam int EDGE_W = dbda_pkg::EDGE_W;
   localparam int PX_W   = PROD_W - dbda_pkg::PROD_SHIFT;

   logic [MAG_W-1:0]  twice_c;
   logic [MAG_W-1:0]  size_ext;
   logic [MAG_W-1:0]  mag_lo_in, mag_hi_in;
   logic              pos_lo_in, pos_hi_in;
   logic [MAG_W-1:0]  mag_lo_ff, mag_hi_ff;
   logic              pos_lo_ff, pos_hi_ff;
   logic [PROD_W-1:0] prod_lo_ff, prod_hi_ff;
   logic              pos_lo2_ff, pos_hi2_ff;

   // stage 1: corner in q12.5, sign split from magnitude
   assign twice_c   = {1'b0, centre, 1'b0};
   assign size_ext  = {2'b00, size};
   assign mag_hi_in = twice_c + size_ext;
   assign pos_hi_in = (mag_hi_in != '0);
   assign pos_lo_in = (twice_c > size_ext);
   assign mag_lo_in = twice_c - size_ext;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         mag_lo_ff <= mag_lo_in;
         mag_hi_ff <= mag_hi_in;
         pos_lo_ff <= pos_lo_in;
         pos_hi_ff <= pos_hi_in;
      end
   end

   // stage 2: scale multiply
   always_ff @(posedge clock) begin
      if (en.s2) begin
         prod_lo_ff <= PROD_W'(mag_lo_ff) * PROD_W'(scale);
         prod_hi_ff <= PROD_W'(mag_hi_ff) * PROD_W'(scale);
         pos_lo2_ff <= pos_lo_ff;
         pos_hi2_ff <= pos_hi_ff;
      end
   end

   // clamp to 0..min(image,4096)-1
   function automatic logic [EDGE_W-1:0] clamp_edge(
      input logic [PROD_W-1:0]          prod,
      input logic                       pos,
      input logic [dbda_pkg::IMG_W-1:0] img
   );
      logic [PX_W-1:0]   px;
      logic [EDGE_W-1:0] lim_m1;
      logic              empty;
      px     = prod[PROD_W-1:dbda_pkg::PROD_SHIFT];
      empty  = (img == '0);
      lim_m1 = img[EDGE_W] ? {EDGE_W{1'b1}} : (img[EDGE_W-1:0] - EDGE_W'(1));
      if (!pos || empty)
         clamp_edge = '0;
      else if (px > PX_W'(lim_m1))
         clamp_edge = lim_m1;
      else
         clamp_edge = px[EDGE_W-1:0];
   endfunction

   assign lo_edge = clamp_edge(prod_lo_ff, pos_lo2_ff, image_size);
   assign hi_edge = clamp_edge(prod_hi_ff, pos_hi2_ff, image_size);

endmodule

/* hdl/dbda_argmax.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbda_argmax
// first highest enabled score: pair lanes, then a short merge over pairs
// ----------------------------------------------------------------------------
module dbda_argmax #(
   parameter int MAX_CLASSES = dbda_pkg::MAX_CLASSES_DEF
) (
   input  logic                                        clock,
   input  dbda_pkg::pipe_en_type                       en,
   input  logic [MAX_CLASSES-1:0][dbda_pkg::SCORE_W-1:0] scores,
   input  logic [MAX_CLASSES-1:0]                      class_en,
   output dbda_pkg::cand_type                          best
);

   localparam int NP    = (MAX_CLASSES + 1) / 2;
   localparam int CNT_W = dbda_pkg::CNT_W;

   // b sits at a higher index, so it wins only on a strictly larger score
   function automatic dbda_pkg::cand_type pick(
      input dbda_pkg::cand_type a,
      input dbda_pkg::cand_type b
   );
      if (b.vld && (!a.vld || (b.score > a.score)))
         pick = b;
      else
         pick = a;
   endfunction

   dbda_pkg::cand_type pair_in [NP];
   dbda_pkg::cand_type pair_ff [NP];
   dbda_pkg::cand_type best_in;
   dbda_pkg::cand_type best_ff;

   genvar p;
   generate
      for (p = 0; p < NP; p++) begin : g_pair
         dbda_pkg::cand_type ca;
         assign ca = '{vld: class_en[2*p], score: scores[2*p], idx: CNT_W'(2*p)};
         if (2*p + 1 < MAX_CLASSES) begin : g_two
            dbda_pkg::cand_type cb;
            assign cb = '{vld: class_en[2*p+1], score: scores[2*p+1],
                          idx: CNT_W'(2*p+1)};
            assign pair_in[p] = pick(ca, cb);
         end else begin : g_one
            assign pair_in[p] = ca;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en.s1) begin
         pair_ff <= pair_in;
      end
   end

   // NP-1 dependent steps over the pair winners, in index order
   always_comb begin
      best_in = pair_ff[0];
      for (int i = 1; i < NP; i++) begin
         best_in = pick(best_in, pair_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

endmodule

/* hdl/detection_box_decode_argmax.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_decode_argmax
// decodes one proposal per item into a clamped image box and best class
// ----------------------------------------------------------------------------
// usage
//   req_* carries one proposal: centre and size in q11.4 model pixels and ten
//   q0.12 class scores packed five to a word. rsp_* carries the kept box
//   edges, the best score and its class index. proposals whose best score is
//   below the threshold give no rsp item.
//   csr_* writes the six settings registers (index 0..5, higher indexes are
//   ignored); write only while no item is in flight.
// timing
//   three-stage pipeline: corner add and pair compare, scale multiply and
//   pair merge, clamp and threshold into the output register. a kept item
//   passes the stage 1 and stage 2 registers into the output register that
//   drives rsp_valid. one item per cycle sustained while rsp_ready is high;
//   the multiply stage sets the clock period.
// reset and stall
//   reset empties the pipeline and loads the register defaults. each stage
//   moves when the next one is free, so req_ready stays high while bubbles
//   remain even though rsp is stalled; only a full pipeline backs up.
// ----------------------------------------------------------------------------
module detection_box_decode_argmax #(
   parameter int MAX_CLASSES = dbda_pkg::MAX_CLASSES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // proposal items in
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dbda_pkg::POS_W-1:0]         req_centre_x,
   input  logic [dbda_pkg::POS_W-1:0]         req_centre_y,
   input  logic [dbda_pkg::POS_W-1:0]         req_box_width,
   input  logic [dbda_pkg::POS_W-1:0]         req_box_height,
   input  logic [dbda_pkg::SCORE_WORD_W-1:0]  req_scores_low,
   input  logic [dbda_pkg::SCORE_WORD_W-1:0]  req_scores_high,
   // detection items out
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dbda_pkg::EDGE_W-1:0]        rsp_left,
   output logic [dbda_pkg::EDGE_W-1:0]        rsp_top,
   output logic [dbda_pkg::EDGE_W-1:0]        rsp_right,
   output logic [dbda_pkg::EDGE_W-1:0]        rsp_bottom,
   output logic [dbda_pkg::SCORE_W-1:0]       rsp_confidence,
   output logic [dbda_pkg::CNT_W-1:0]         rsp_class_index,
   // settings write port
   input  logic                               csr_wr_en,
   input  logic [dbda_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dbda_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int SCORE_W = dbda_pkg::SCORE_W;
   localparam int CNT_W   = dbda_pkg::CNT_W;
   localparam int EDGE_W  = dbda_pkg::EDGE_W;
   localparam int IMG_W   = dbda_pkg::IMG_W;
   localparam int SPW     = dbda_pkg::SCORES_PER_WORD;

   // settings registers
   logic [dbda_pkg::SCALE_W-1:0] scale_x_ff, scale_y_ff;
   logic [IMG_W-1:0]             image_width_ff, image_height_ff;
   logic [SCORE_W-1:0]           thresh_ff;
   logic [CNT_W-1:0]             class_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff      <= dbda_pkg::SCALE_RESET;
         scale_y_ff      <= dbda_pkg::SCALE_RESET;
         image_width_ff  <= dbda_pkg::IMAGE_RESET;
         image_height_ff <= dbda_pkg::IMAGE_RESET;
         thresh_ff       <= dbda_pkg::THRESH_RESET;
         class_count_ff  <= dbda_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dbda_pkg::REG_SCALE_X:      scale_x_ff      <= csr_wr_data;
            dbda_pkg::REG_SCALE_Y:      scale_y_ff      <= csr_wr_data;
            dbda_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_wr_data[IMG_W-1:0];
            dbda_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_wr_data[IMG_W-1:0];
            dbda_pkg::REG_SCORE_THRESH: thresh_ff       <= csr_wr_data[SCORE_W-1:0];
            dbda_pkg::REG_CLASS_COUNT:  class_count_ff  <= csr_wr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control: a stage advances when it is empty or the next one moves
   logic                  v1_ff, v2_ff, rsp_valid_ff;
   logic                  en3;
   dbda_pkg::pipe_en_type pen;
   logic                  keep;

   assign en3       = !rsp_valid_ff || rsp_ready;
   assign pen.s2    = !v2_ff || en3;
   assign pen.s1    = !v1_ff || pen.s2;
   assign req_ready = pen.s1;

   // effective class count: zero means one, capped at the lane count
   logic [CNT_W-1:0]       n_eff;
   logic [MAX_CLASSES-1:0] class_en;

   always_comb begin
      if (class_count_ff > CNT_W'(MAX_CLASSES))
         n_eff = CNT_W'(MAX_CLASSES);
      else if (class_count_ff == '0)
         n_eff = CNT_W'(1);
      else
         n_eff = class_count_ff;
   end

   // unpack score lanes
   logic [MAX_CLASSES-1:0][SCORE_W-1:0] scores;

   genvar c;
   generate
      for (c = 0; c < MAX_CLASSES; c++) begin : g_score
         if (c < SPW) begin : g_low
            assign scores[c] = req_scores_low[c*SCORE_W +: SCORE_W];
         end else begin : g_high
            assign scores[c] = req_scores_high[(c-SPW)*SCORE_W +: SCORE_W];
         end
         assign class_en[c] = (CNT_W'(c) < n_eff);
      end
   endgenerate

   // corner lanes, one per axis
   logic [EDGE_W-1:0] left_w, right_w, top_w, bottom_w;

   dbda_axis_lane u_lane_x (
      .clock      (clock),
      .en         (pen),
      .centre     (req_centre_x),
      .size       (req_box_width),
      .scale      (scale_x_ff),
      .image_size (image_width_ff),
      .lo_edge    (left_w),
      .hi_edge    (right_w)
   );

   dbda_axis_lane u_lane_y (
      .clock      (clock),
      .en         (pen),
      .centre     (req_centre_y),
      .size       (req_box_height),
      .scale      (scale_y_ff),
      .image_size (image_height_ff),
      .lo_edge    (top_w),
      .hi_edge    (bottom_w)
   );

   // best class
   dbda_pkg::cand_type best;

   dbda_argmax #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_argmax (
      .clock    (clock),
      .en       (pen),
      .scores   (scores),
      .class_en (class_en),
      .best     (best)
   );

   // merge: threshold decides whether the item leaves the block
   assign keep = (best.score >= thresh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pen.s1) v1_ff        <= req_valid;
         if (pen.s2) v2_ff        <= v1_ff;
         if (en3)    rsp_valid_ff <= v2_ff && keep;
      end
   end

   // output register, payload only
   logic [EDGE_W-1:0]  left_ff, top_ff, right_ff, bottom_ff;
   logic [SCORE_W-1:0] conf_ff;
   logic [CNT_W-1:0]   cls_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         left_ff   <= left_w;
         top_ff    <= top_w;
         right_ff  <= right_w;
         bottom_ff <= bottom_w;
         conf_ff   <= best.score;
         cls_ff    <= best.idx;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left        = left_ff;
   assign rsp_top         = top_ff;
   assign rsp_right       = right_ff;
   assign rsp_bottom      = bottom_ff;
   assign rsp_confidence  = conf_ff;
   assign rsp_class_index = cls_ff;

endmodule
